### rtl/core/tss_pkg.sv
// Shared types, command codes and constants of the triangle seek steering block.
package tss_pkg;

  // Iteration index width (CORDIC step indexes 0 to 31)
  localparam int ITER_W = 5;
  // CORDIC angle width, 2^-16 degree units
  localparam int ZW = 28;
  // sin/cos width, Q24
  localparam int CSW = 26;

  localparam logic signed [ZW-1:0] ANG_FULL  = 28'sd23592960;
  localparam logic signed [ZW-1:0] ANG_HALF  = 28'sd11796480;
  localparam logic signed [ZW-1:0] ANG_QUART = 28'sd5898240;
  localparam logic signed [31:0]   INV_GAIN  = 32'sd652032874;
  localparam logic signed [20:0]   HEAD_MAX  = 21'sd46080;
  localparam logic signed [20:0]   HEAD_MIN  = -21'sd46080;
  localparam logic [9:0]           SPEED_RESET = 10'd300;

  // Configuration register indexes
  localparam logic [2:0] REG_V0_X    = 3'd0;
  localparam logic [2:0] REG_V0_Y    = 3'd1;
  localparam logic [2:0] REG_V1_X    = 3'd2;
  localparam logic [2:0] REG_V1_Y    = 3'd3;
  localparam logic [2:0] REG_TIP_X   = 3'd4;
  localparam logic [2:0] REG_TIP_Y   = 3'd5;
  localparam logic [2:0] REG_SPEED   = 3'd6;
  localparam logic [2:0] REG_HEADING = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIR, ST_CHK, ST_VEC, ST_HEAD, ST_ROT, ST_RRED, ST_RLOAD, ST_RCOR,
    ST_RFIN, ST_VM1, ST_VM2, ST_VSUM, ST_VLD, ST_VDIV, ST_VWR, ST_COMMIT, ST_MSET,
    ST_MRED, ST_MLOAD, ST_MCOR, ST_MFIN, ST_MX, ST_MY, ST_MADD, ST_OUT
  } tss_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_DIR, OP_VLOAD, OP_CSTEP, OP_HEAD, OP_ROT, OP_RED,
    OP_CLOAD, OP_CFIN, OP_VMUL1, OP_VMUL2, OP_VSUM, OP_DLOAD, OP_DSTEP, OP_VWR,
    OP_COMMIT, OP_MSET, OP_MX, OP_MY, OP_MADD, OP_OUT
  } tss_op_t;

  typedef struct packed {
    tss_op_t           op;
    logic [ITER_W-1:0] iter;
    logic [2:0]        vidx;
  } tss_cmd_t;

  typedef struct packed {
    logic skip;
    logic rot_zero;
    logic red_done;
  } tss_status_t;

  // Arctangent table, 2^-16 degree units
  function automatic logic [21:0] atan_val(input logic [ITER_W-1:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/triangle_seek_steering_step.sv
// Top level of the triangle seek steering step: sequencer plus datapath.
//
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    tdata: target x,y,w,h, time_step; tuser: restart
// out_     out  out_tvalid/out_tready  tdata: v0..tip x,y, heading, reached
// cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One word at a time. A restart, a skipped step (aim at center, zero speed or zero
// time), a move without turn and a move with turn each take their own path; a move with
// turn adds the three vertex rotations, which run on the shared CORDIC and the
// digit-serial divide by 3.
// Reset (rst_n low, synchronous) loads reset config into vertices and heading.
// A new word is taken while a finished result waits; out_tready stalls only the last state.
module triangle_seek_steering_step import tss_pkg::*; #(
  parameter int COORD_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [15:0] target_x, [31:16] target_y, [46:32] target_w, [61:47] target_h,
  // [77:62] time_step, [79:78] zero
  input  logic [79:0]  in_tdata,
  // [0] restart
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] v0_x, [31:16] v0_y, [47:32] v1_x, [63:48] v1_y, [79:64] tip_x,
  // [95:80] tip_y, [112:96] heading, [113] reached, [119:114] zero
  output logic [119:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [16:0]  cfg_data
);

  tss_cmd_t    cmd;
  tss_status_t status;

  // Register writes are taken whenever reset is released
  assign cfg_ready = rst_n;

  tss_ctrl #(
    .COORD_WIDTH (COORD_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_restart(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tss_dp #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_restart  (in_tuser),
    .in_target_x (in_tdata[15:0]),
    .in_target_y (in_tdata[31:16]),
    .in_target_w (in_tdata[46:32]),
    .in_target_h (in_tdata[61:47]),
    .in_time_step(in_tdata[77:62]),
    .cmd         (cmd),
    .status      (status),
    .out_word    (out_tdata)
  );

endmodule

### rtl/core/tss_ctrl.sv
// Sequencer of the steering step: state machine, step counters and output valid.
module tss_ctrl import tss_pkg::*; #(
  parameter int COORD_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_restart,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  tss_status_t status,
  output tss_cmd_t    cmd
);

  localparam int UW   = COORD_WIDTH + 5;
  localparam int NDIG = (UW + 3) / 4;
  localparam int DCW  = $clog2(NDIG);
  localparam logic [ITER_W-1:0] LAST_STEP = ITER_W'(CORDIC_STEPS - 1);
  localparam logic [DCW-1:0]    LAST_DIG  = DCW'(NDIG - 1);

  tss_state_t        state_r, state_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic [DCW-1:0]    dcnt_r, dcnt_nxt;
  logic [2:0]        vidx_r, vidx_nxt;
  logic              out_valid_r, out_valid_nxt;
  tss_op_t           op;

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      dcnt_r      <= '0;
      vidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dcnt_r      <= dcnt_nxt;
      vidx_r      <= vidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dcnt_nxt  = dcnt_r;
    vidx_nxt  = vidx_r;
    op        = OP_NONE;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // No word is taken while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          op        = OP_ACCEPT;
          state_nxt = in_restart ? ST_OUT : ST_DIR;
        end
      end
      ST_DIR: begin
        op        = OP_DIR;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (status.skip) begin
          state_nxt = ST_OUT;
        end else begin
          op        = OP_VLOAD;
          cnt_nxt   = '0;
          state_nxt = ST_VEC;
        end
      end
      ST_VEC: begin
        op = OP_CSTEP;
        if (cnt_r == LAST_STEP) state_nxt = ST_HEAD;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_HEAD: begin
        op        = OP_HEAD;
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        op        = OP_ROT;
        state_nxt = status.rot_zero ? ST_MSET : ST_RRED;
      end
      ST_RRED: begin
        if (status.red_done) state_nxt = ST_RLOAD;
        else op = OP_RED;
      end
      ST_RLOAD: begin
        op        = OP_CLOAD;
        cnt_nxt   = '0;
        state_nxt = ST_RCOR;
      end
      ST_RCOR: begin
        op = OP_CSTEP;
        if (cnt_r == LAST_STEP) state_nxt = ST_RFIN;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_RFIN: begin
        op        = OP_CFIN;
        vidx_nxt  = '0;
        state_nxt = ST_VM1;
      end
      ST_VM1: begin
        op        = OP_VMUL1;
        state_nxt = ST_VM2;
      end
      ST_VM2: begin
        op        = OP_VMUL2;
        state_nxt = ST_VSUM;
      end
      ST_VSUM: begin
        op        = OP_VSUM;
        state_nxt = ST_VLD;
      end
      ST_VLD: begin
        op        = OP_DLOAD;
        dcnt_nxt  = '0;
        state_nxt = ST_VDIV;
      end
      ST_VDIV: begin
        op = OP_DSTEP;
        if (dcnt_r == LAST_DIG) state_nxt = ST_VWR;
        else dcnt_nxt = dcnt_r + 1'b1;
      end
      ST_VWR: begin
        op = OP_VWR;
        if (vidx_r == 3'd5) begin
          state_nxt = ST_COMMIT;
        end else begin
          vidx_nxt  = vidx_r + 1'b1;
          state_nxt = ST_VM1;
        end
      end
      ST_COMMIT: begin
        op        = OP_COMMIT;
        state_nxt = ST_MSET;
      end
      ST_MSET: begin
        op        = OP_MSET;
        state_nxt = ST_MRED;
      end
      ST_MRED: begin
        if (status.red_done) state_nxt = ST_MLOAD;
        else op = OP_RED;
      end
      ST_MLOAD: begin
        op        = OP_CLOAD;
        cnt_nxt   = '0;
        state_nxt = ST_MCOR;
      end
      ST_MCOR: begin
        op = OP_CSTEP;
        if (cnt_r == LAST_STEP) state_nxt = ST_MFIN;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_MFIN: begin
        op        = OP_CFIN;
        state_nxt = ST_MX;
      end
      ST_MX: begin
        op        = OP_MX;
        state_nxt = ST_MY;
      end
      ST_MY: begin
        op        = OP_MY;
        state_nxt = ST_MADD;
      end
      ST_MADD: begin
        op        = OP_MADD;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          op        = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output word valid: set on load, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (op == OP_OUT) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign cmd.op     = op;
  assign cmd.iter   = cnt_r;
  assign cmd.vidx   = vidx_r;

endmodule

### rtl/core/tss_dp.sv
// Datapath: configuration, vertex and heading state, shared CORDIC, divide by three.
module tss_dp import tss_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_restart,
  input  logic signed [15:0] in_target_x,
  input  logic signed [15:0] in_target_y,
  input  logic [14:0]        in_target_w,
  input  logic [14:0]        in_target_h,
  input  logic [15:0]        in_time_step,
  input  tss_cmd_t           cmd,
  output tss_status_t        status,
  output logic [119:0]       out_word
);

  localparam int CW   = COORD_WIDTH;
  localparam int BW   = (CW > 16) ? CW : 16;
  localparam int DXW  = BW + 3;
  localparam int VW   = DXW + 22;
  localparam int QW   = CW + 4;
  localparam int UW   = QW + 1;
  localparam int NDIG = (UW + 3) / 4;
  localparam int DVW  = NDIG * 4;
  localparam int RLW  = CW + 2;
  localparam int PW   = RLW + CSW;
  localparam int NW   = CW + 29;
  localparam int SW   = CW + 6;
  localparam int AW   = BW + 2;
  localparam int HPW  = 37;
  localparam int PMW  = 53;
  localparam int MW   = PMW - 40;

  localparam logic signed [SW-1:0] CMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic [UW-1:0]        DOFF = UW'(3) << (QW - 1);
  localparam logic [QW-1:0]        QOFF = QW'(1) << (QW - 1);
  localparam logic signed [NW-1:0] RND  = NW'(25165824);
  localparam logic signed [PMW-1:0] TRND = PMW'(64'h0000_00FF_FFFF_FFFF);

  // Saturate to the coordinate range
  function automatic logic signed [CW-1:0] sat_cw(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
    return t[CW-1:0];
  endfunction

  function automatic logic signed [16:0] sat_head(input logic signed [20:0] v);
    logic signed [20:0] t;
    t = (v > HEAD_MAX) ? HEAD_MAX : ((v < HEAD_MIN) ? HEAD_MIN : v);
    return t[16:0];
  endfunction

  function automatic logic [15:0] to16(input logic signed [CW-1:0] v);
    logic signed [SW-1:0] e;
    e = SW'(v);
    return e[15:0];
  endfunction

  // Truncate toward zero by 2^40
  function automatic logic signed [MW-1:0] trunc40(input logic signed [PMW-1:0] p);
    logic signed [PMW-1:0] t;
    t = (p < 0) ? ((p + TRND) >>> 40) : (p >>> 40);
    return t[MW-1:0];
  endfunction

  // Architectural state
  logic signed [15:0] cfg_pos_r [6];
  logic [9:0]         cfg_speed_r;
  logic signed [16:0] cfg_head_r;
  logic signed [CW-1:0] vtx_r [6];
  logic signed [16:0]   heading_r;

  // Working registers
  logic signed [15:0]   tx_r, ty_r;
  logic [14:0]          tw_r, th_r;
  logic [15:0]          ts_r;
  logic [25:0]          st_r;
  logic signed [DXW-1:0] dx_r, dy_r;
  logic signed [VW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r, zdir_r, ang_r;
  logic                 mode_vec_r, neg_r;
  logic signed [HPW-1:0] hprod_r;
  logic signed [RLW-1:0] sx_r, sy_r;
  logic signed [RLW-1:0] relx_r [3];
  logic signed [RLW-1:0] rely_r [3];
  logic signed [CSW-1:0] c_r, s_r;
  logic signed [PW-1:0]  p1_r, p2_r;
  logic signed [NW-1:0]  acc_r;
  logic [DVW-1:0]        div_r, quo_r;
  logic [1:0]            rem_r;
  logic signed [CW-1:0]  new_r [6];
  logic signed [PMW-1:0] pm_r;
  logic signed [MW-1:0]  mx_r;
  logic [119:0]          out_word_r;

  // Combinational helpers
  logic signed [DXW-1:0] dx_c, dy_c, xsel, ysel;
  logic signed [ZW-1:0]  zsel, at_c, zrnd, ht_c, a1, a2;
  logic signed [VW-1:0]  xs_c, ys_c, xn_c, yn_c;
  logic                  pos_c, neg_c;
  logic signed [19:0]    diff_c;
  logic signed [HPW-1:0] rot_full;
  logic signed [20:0]    rot_c;
  logic [1:0]            pair;
  logic                  odd;
  logic signed [NW-1:0]  qsh;
  logic [UW-1:0]         u_c;
  logic [3:0]            dig, qd;
  logic [1:0]            r_c;
  logic [2:0]            t_c;
  logic [QW-1:0]         qv_c;
  logic signed [MW-1:0]  my_c;
  logic signed [AW-1:0]  tipx, tipy, lox, loy, hix, hiy;
  logic                  reached_c;

  // Aim vector from tip to target center, times two
  always_comb begin
    dx_c = (DXW'(tx_r) <<< 1) + DXW'(signed'({1'b0, tw_r})) - (DXW'(vtx_r[4]) <<< 1);
    dy_c = (DXW'(ty_r) <<< 1) + DXW'(signed'({1'b0, th_r})) - (DXW'(vtx_r[5]) <<< 1);
  end

  // Vectoring preswap into the right half plane
  always_comb begin
    xsel = dx_r;
    ysel = dy_r;
    zsel = '0;
    if (dx_r < 0) begin
      if (dy_r >= 0) begin
        xsel = dy_r;
        ysel = -dx_r;
        zsel = ANG_QUART;
      end else begin
        xsel = -dy_r;
        ysel = dx_r;
        zsel = -ANG_QUART;
      end
    end
  end

  // One CORDIC micro-rotation
  always_comb begin
    xs_c  = cx_r >>> cmd.iter;
    ys_c  = cy_r >>> cmd.iter;
    at_c  = ZW'(signed'({1'b0, atan_val(cmd.iter)}));
    pos_c = mode_vec_r ? (cy_r < 0) : (cz_r >= 0);
  end

  // Heading rounding and turn amount
  always_comb begin
    zrnd     = cz_r + ZW'(256);
    ht_c     = zrnd >>> 9;
    diff_c   = 20'(ht_c) - 20'(heading_r);
    rot_full = hprod_r >>> 16;
    rot_c    = rot_full[20:0];
  end

  // Fold a reduced angle into the right half plane
  always_comb begin
    a1    = (ang_r > ANG_HALF) ? (ang_r - ANG_FULL) : ang_r;
    a2    = a1;
    neg_c = 1'b0;
    if (a1 > ANG_QUART) begin
      a2    = a1 - ANG_HALF;
      neg_c = 1'b1;
    end else if (a1 < -ANG_QUART) begin
      a2    = a1 + ANG_HALF;
      neg_c = 1'b1;
    end
  end

  // CORDIC output sign fix
  always_comb begin
    xn_c = neg_r ? -cx_r : cx_r;
    yn_c = neg_r ? -cy_r : cy_r;
  end

  // Vertex rotation and divide by three
  always_comb begin
    pair = cmd.vidx[2:1];
    odd  = cmd.vidx[0];
    qsh  = acc_r >>> 24;
    u_c  = UW'(qsh[QW-1:0]) + DOFF;
    u_c  = UW'(signed'(qsh[QW-1:0])) + DOFF;
    dig  = div_r[DVW-1 -: 4];
    r_c  = rem_r;
    qd   = '0;
    t_c  = '0;
    for (int j = 3; j >= 0; j--) begin
      t_c = {r_c, dig[j]};
      if (t_c >= 3'd3) begin
        qd[j] = 1'b1;
        t_c   = t_c - 3'd3;
      end
      r_c = t_c[1:0];
    end
    qv_c = quo_r[QW-1:0] - QOFF;
  end

  // Motion and target test
  always_comb begin
    my_c = trunc40(pm_r);
    tipx = AW'(vtx_r[4]);
    tipy = AW'(vtx_r[5]);
    lox  = AW'(tx_r);
    loy  = AW'(ty_r);
    hix  = lox + AW'(signed'({1'b0, tw_r}));
    hiy  = loy + AW'(signed'({1'b0, th_r}));
    reached_c = (tipx >= lox) && (tipx < hix) && (tipy >= loy) && (tipy < hiy);
  end

  assign status.skip     = ((dx_r == '0) && (dy_r == '0)) || (cfg_speed_r == '0)
                           || (ts_r == '0);
  assign status.rot_zero = (rot_c == '0);
  assign status.red_done = (ang_r >= 0) && (ang_r < ANG_FULL);

  // Configuration, vertices and heading
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 6; k++) begin
        cfg_pos_r[k] <= '0;
        vtx_r[k]     <= '0;
      end
      cfg_speed_r <= SPEED_RESET;
      cfg_head_r  <= '0;
      heading_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_V0_X:    cfg_pos_r[0] <= cfg_data[15:0];
          REG_V0_Y:    cfg_pos_r[1] <= cfg_data[15:0];
          REG_V1_X:    cfg_pos_r[2] <= cfg_data[15:0];
          REG_V1_Y:    cfg_pos_r[3] <= cfg_data[15:0];
          REG_TIP_X:   cfg_pos_r[4] <= cfg_data[15:0];
          REG_TIP_Y:   cfg_pos_r[5] <= cfg_data[15:0];
          REG_SPEED:   cfg_speed_r  <= cfg_data[9:0];
          REG_HEADING: cfg_head_r   <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_ACCEPT: begin
          if (in_restart) begin
            for (int k = 0; k < 6; k++) vtx_r[k] <= sat_cw(SW'(cfg_pos_r[k]));
            heading_r <= sat_head(21'(cfg_head_r));
          end
        end
        OP_ROT: begin
          if (rot_c != '0) heading_r <= sat_head(21'(heading_r) + rot_c);
        end
        OP_COMMIT: begin
          for (int k = 0; k < 6; k++) vtx_r[k] <= new_r[k];
        end
        OP_MADD: begin
          for (int k = 0; k < 6; k++) begin
            if (k[0]) vtx_r[k] <= sat_cw(SW'(AW'(vtx_r[k]) + (AW'(my_c) <<< 4)));
            else      vtx_r[k] <= sat_cw(SW'(AW'(vtx_r[k]) + (AW'(mx_r) <<< 4)));
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        tx_r <= in_target_x;
        ty_r <= in_target_y;
        tw_r <= in_target_w;
        th_r <= in_target_h;
        ts_r <= in_time_step;
      end
      OP_DIR: begin
        dx_r <= dx_c;
        dy_r <= dy_c;
        st_r <= 26'(cfg_speed_r) * 26'(ts_r);
      end
      OP_VLOAD: begin
        cx_r       <= VW'(xsel) <<< 20;
        cy_r       <= VW'(ysel) <<< 20;
        cz_r       <= zsel;
        mode_vec_r <= 1'b1;
      end
      OP_CSTEP: begin
        if (pos_c) begin
          cx_r <= cx_r - ys_c;
          cy_r <= cy_r + xs_c;
          cz_r <= cz_r - at_c;
        end else begin
          cx_r <= cx_r + ys_c;
          cy_r <= cy_r - xs_c;
          cz_r <= cz_r + at_c;
        end
      end
      OP_HEAD: begin
        zdir_r  <= cz_r;
        hprod_r <= HPW'(diff_c) * HPW'(signed'({1'b0, ts_r}));
      end
      OP_ROT: begin
        ang_r <= {rot_c[ZW-10:0], 9'b0};
        sx_r  <= RLW'(vtx_r[0]) + RLW'(vtx_r[2]) + RLW'(vtx_r[4]);
        sy_r  <= RLW'(vtx_r[1]) + RLW'(vtx_r[3]) + RLW'(vtx_r[5]);
      end
      OP_RED: begin
        if (ang_r < 0) ang_r <= ang_r + ANG_FULL;
        else ang_r <= ang_r - ANG_FULL;
      end
      OP_CLOAD: begin
        cx_r       <= VW'(INV_GAIN);
        cy_r       <= '0;
        cz_r       <= a2;
        neg_r      <= neg_c;
        mode_vec_r <= 1'b0;
        // Offsets from the centroid, times three
        for (int j = 0; j < 3; j++) begin
          relx_r[j] <= (RLW'(vtx_r[2*j]) <<< 1) + RLW'(vtx_r[2*j]) - sx_r;
          rely_r[j] <= (RLW'(vtx_r[2*j+1]) <<< 1) + RLW'(vtx_r[2*j+1]) - sy_r;
        end
      end
      OP_CFIN: begin
        c_r <= CSW'((xn_c + VW'(32)) >>> 6);
        s_r <= CSW'((yn_c + VW'(32)) >>> 6);
      end
      OP_VMUL1: p1_r <= PW'(relx_r[pair]) * PW'(odd ? s_r : c_r);
      OP_VMUL2: p2_r <= PW'(rely_r[pair]) * PW'(odd ? c_r : s_r);
      OP_VSUM: begin
        acc_r <= (NW'(odd ? sy_r : sx_r) <<< 24) + NW'(p1_r)
                 + (odd ? NW'(p2_r) : -NW'(p2_r)) + RND;
      end
      OP_DLOAD: begin
        div_r <= DVW'(u_c);
        quo_r <= '0;
        rem_r <= '0;
      end
      OP_DSTEP: begin
        div_r <= div_r << 4;
        quo_r <= {quo_r[DVW-5:0], qd};
        rem_r <= r_c;
      end
      OP_VWR:  new_r[cmd.vidx] <= sat_cw(SW'(signed'(qv_c)));
      OP_MSET: ang_r <= zdir_r;
      OP_MX:   pm_r <= PMW'(signed'({1'b0, st_r})) * PMW'(c_r);
      OP_MY: begin
        mx_r <= trunc40(pm_r);
        pm_r <= PMW'(signed'({1'b0, st_r})) * PMW'(s_r);
      end
      OP_OUT: begin
        out_word_r <= {6'b0, reached_c, heading_r, to16(vtx_r[5]), to16(vtx_r[4]),
                       to16(vtx_r[3]), to16(vtx_r[2]), to16(vtx_r[1]), to16(vtx_r[0])};
      end
      default: ;
    endcase
  end

  assign out_word = out_word_r;

endmodule

### test/tb.sv
// Testbench for triangle_seek_steering_step: random and directed steps against a predictor.
`timescale 1ns / 100ps

module tb import tss_pkg::*;;

  localparam longint CYCLE_LIMIT = 1500000;
  localparam int     SETTLE = 300;
  localparam longint HEAD_LIM = 46080;

  typedef struct {
    bit          restart;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [14:0] tw;
    logic [14:0] th;
    logic [15:0] ts;
  } step_word_t;

  typedef struct {
    logic [15:0] vtx[6];
    logic [16:0] heading;
    logic        reached;
  } pose_word_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [79:0]  in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [119:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [16:0]  cfg_data;

  step_word_t steps_pending[$];
  pose_word_t poses_expected[$];
  int         errors = 0;
  longint     cycles = 0;
  bit         no_idle = 0;
  bit         long_hold_req = 0;
  bit         in_held = 0;
  int         in_gap = 0;
  int         out_gap = 0;
  int         hold_cnt = 0;

  // steering state copy
  longint cfg_regs[8];
  longint tri_vtx[6];
  longint head_q;

  triangle_seek_steering_step dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic longint atan_step(int i);
    longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                        14668, 7334, 3667, 1833, 917, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1, 0};
    return tab[i];
  endfunction

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if (a % b != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint clamp_coord(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic longint clamp_head(longint v);
    return v > HEAD_LIM ? HEAD_LIM : (v < -HEAD_LIM ? -HEAD_LIM : v);
  endfunction

  function automatic void reload_pose();
    for (int k = 0; k < 6; k++) tri_vtx[k] = clamp_coord(longint'($signed(cfg_regs[k][15:0])));
    head_q = clamp_head(longint'($signed(cfg_regs[7][16:0])));
  endfunction

  // Q24 cos/sin of an angle in 2^-16 degree
  function automatic void cos_sin_q24(input longint a, output longint c, output longint s);
    longint x, y, z, xs, ys;
    bit neg;
    x = 652032874; y = 0; neg = 0;
    a = a - floor_div(a, 23592960) * 23592960;
    if (a > 11796480) a -= 23592960;
    if (a > 5898240) begin
      a -= 11796480; neg = 1;
    end else if (a < -5898240) begin
      a += 11796480; neg = 1;
    end
    z = a;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_step(i);
      end else begin
        x += ys; y -= xs; z += atan_step(i);
      end
    end
    if (neg) begin
      x = -x; y = -y;
    end
    c = (x + 32) >>> 6;
    s = (y + 32) >>> 6;
  endfunction

  // direction angle in 2^-16 degree by vectoring
  function automatic longint aim_angle(longint dx, longint dy);
    longint x, y, z, xs, ys;
    z = 0;
    if (dx < 0) begin
      if (dy >= 0) begin
        x = dy; y = -dx; z = 90 * 65536;
      end else begin
        x = -dy; y = dx; z = -90 * 65536;
      end
    end else begin
      x = dx; y = dy;
    end
    x = x * (64'sd1 << 20);
    y = y * (64'sd1 << 20);
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  // one steering step on the state copy
  function automatic pose_word_t steer_step(step_word_t w);
    pose_word_t r;
    longint tx, ty, tw, th, ts, spd, dx, dy, z, c, s, ht, rot, sx, sy, rx, ry, nx, ny, mx, my;
    tx = longint'($signed(w.tx)); ty = longint'($signed(w.ty));
    tw = w.tw; th = w.th; ts = w.ts; spd = cfg_regs[6] & 1023;
    if (w.restart) begin
      reload_pose();
    end else begin
      dx = 2 * tx + tw - 2 * tri_vtx[4];
      dy = 2 * ty + th - 2 * tri_vtx[5];
      if ((dx != 0 || dy != 0) && spd != 0 && ts != 0) begin
        z = aim_angle(dx, dy);
        ht = (z + 256) >>> 9;
        rot = floor_div((ht - head_q) * ts, 65536);
        if (rot != 0) begin
          sx = tri_vtx[0] + tri_vtx[2] + tri_vtx[4];
          sy = tri_vtx[1] + tri_vtx[3] + tri_vtx[5];
          cos_sin_q24(rot * 512, c, s);
          for (int k = 0; k < 3; k++) begin
            rx = 3 * tri_vtx[2*k] - sx;
            ry = 3 * tri_vtx[2*k+1] - sy;
            nx = sx * (64'sd1 << 24) + rx * c - ry * s;
            ny = sy * (64'sd1 << 24) + rx * s + ry * c;
            tri_vtx[2*k]   = clamp_coord(floor_div(nx + 3 * (64'sd1 << 23), 3 * (64'sd1 << 24)));
            tri_vtx[2*k+1] = clamp_coord(floor_div(ny + 3 * (64'sd1 << 23), 3 * (64'sd1 << 24)));
          end
          head_q = clamp_head(head_q + rot);
        end
        cos_sin_q24(z, c, s);
        mx = spd * ts * c / (64'sd1 << 40);
        my = spd * ts * s / (64'sd1 << 40);
        for (int k = 0; k < 3; k++) begin
          tri_vtx[2*k]   = clamp_coord(tri_vtx[2*k] + 16 * mx);
          tri_vtx[2*k+1] = clamp_coord(tri_vtx[2*k+1] + 16 * my);
        end
      end
    end
    for (int k = 0; k < 6; k++) r.vtx[k] = tri_vtx[k][15:0];
    r.heading = head_q[16:0];
    r.reached = (tri_vtx[4] >= tx && tri_vtx[4] < tx + tw &&
                 tri_vtx[5] >= ty && tri_vtx[5] < ty + th);
    return r;
  endfunction

  // input side: accept at posedge, drive at negedge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      poses_expected.push_back(steer_step(steps_pending.pop_front()));
      in_held = 0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_held) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 5);
        in_tvalid <= 1'b0;
      end else if (steps_pending.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {2'b00, steps_pending[0].ts, steps_pending[0].th, steps_pending[0].tw,
                     steps_pending[0].ty, steps_pending[0].tx};
        in_tuser <= steps_pending[0].restart;
        in_held = 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side: ready bursts and one long hold-off
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 0;
      hold_cnt = 600;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result check
  always @(posedge clk) begin
    pose_word_t e;
    logic [15:0] got;
    if (rst_n && out_tvalid && out_tready) begin
      if (poses_expected.size() == 0) begin
        $display("%0t: result word with nothing expected: %h", $realtime, out_tdata);
        errors++;
      end else begin
        e = poses_expected.pop_front();
        for (int k = 0; k < 6; k++) begin
          got = out_tdata[16*k +: 16];
          if (got !== e.vtx[k]) begin
            $display("%0t: vertex coord %0d expected %0d got %0d", $realtime, k,
                     $signed(e.vtx[k]), $signed(got));
            errors++;
          end
        end
        if (out_tdata[112:96] !== e.heading) begin
          $display("%0t: heading expected %0d got %0d", $realtime, $signed(e.heading),
                   $signed(out_tdata[112:96]));
          errors++;
        end
        if (out_tdata[113] !== e.reached) begin
          $display("%0t: reached expected %0b got %0b", $realtime, e.reached, out_tdata[113]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("triangle_seek_steering_step regression: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_regs[idx] = (idx == REG_SPEED) ? (val & 17'h3FF) :
                    (idx == REG_HEADING) ? longint'(val) : (val & 17'hFFFF);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (steps_pending.size() > 0 || poses_expected.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_step(bit rs, int tx, int ty, int tw, int th, int ts);
    step_word_t w;
    w.restart = rs; w.tx = tx; w.ty = ty; w.tw = tw; w.th = th; w.ts = ts;
    steps_pending.push_back(w);
  endtask

  // mostly targets in a modest arena, sometimes anywhere
  task automatic push_random(int n);
    int span;
    repeat (n) begin
      span = ($urandom_range(0, 9) == 0) ? 32767 : 3000;
      if ($urandom_range(0, 39) == 0)
        push_step(1, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        push_step(0, $urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 800),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 800),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) :
                                                $urandom_range(0, 4000));
    end
  endtask

  task automatic load_set(int a, int b, int c, int d, int e, int f, int spd, int hd);
    wait_drained();
    write_reg(REG_V0_X, a);
    write_reg(REG_V0_Y, b);
    write_reg(REG_V1_X, c);
    write_reg(REG_V1_Y, d);
    write_reg(REG_TIP_X, e);
    write_reg(REG_TIP_Y, f);
    write_reg(REG_SPEED, spd);
    write_reg(REG_HEADING, hd);
    push_step(1, 0, 0, 0, 0, 0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_V0_X; cfg_data = '0;
    for (int k = 0; k < 8; k++) cfg_regs[k] = 0;
    cfg_regs[6] = 300;
    reload_pose();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: tip at origin after reset
    push_step(0, -5, -5, 10, 10, 1000);           // tip on target center
    push_step(0, 1000, 1000, 50, 50, 0);          // zero time step
    push_step(1, 0, 0, 1, 1, 0);                  // restart, tip inside
    push_step(0, 32767, 32767, 32767, 32767, 65535);
    push_step(0, -32768, -32768, 0, 0, 65535);
    push_step(0, -32768, 32767, 32767, 0, 40000);
    push_step(0, 32767, -32768, 0, 32767, 1);
    push_step(0, 0, 0, 0, 0, 0);
    push_step(0, 100, -300, 7, 9, 20000);
    // hold the receiver so the block backs up
    long_hold_req = 1;
    push_random(12);

    // extremes of vertices, top speed, heading at its limit
    load_set(32767, -32768, -32768, 32767, 32767, 32767, 1023, 46080);
    push_step(0, -32768, -32768, 1, 1, 65535);
    push_step(0, 32767, 32767, 32767, 32767, 65535);
    push_random(60);

    // zero speed: no motion at all
    load_set(16, 16, -16, 16, 0, -48, 0, -46080);
    push_random(40);

    // heading beyond range is clamped on load
    load_set(-320, 0, 320, 0, 0, 400, 700, 17'h10000);
    push_random(60);
    load_set(0, 0, 0, 0, 0, 0, 1, 17'hFFFF);
    push_random(40);

    // bulk random settings
    for (int p = 0; p < 6; p++) begin
      load_set($urandom_range(0, 1200) - 600, $urandom_range(0, 1200) - 600,
               $urandom_range(0, 1200) - 600, $urandom_range(0, 1200) - 600,
               $urandom_range(0, 1200) - 600, $urandom_range(0, 1200) - 600,
               $urandom_range(0, 1023), $urandom_range(0, 92160) - 46080);
      push_random(200);
    end

    // last stretch without idling
    wait_drained();
    no_idle = 1;
    push_random(150);
    wait_drained();

    if (errors == 0) begin
      $display("triangle_seek_steering_step regression: pass");
    end else begin
      $display("triangle_seek_steering_step regression: fail");
    end
    $finish;
  end

endmodule
